// File: rtl/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg: shared types and constants for the tire magic formula core
// Fixed-point angle constants (Q.24), CORDIC arctangent table, register map.
// ----------------------------------------------------------------------------
package tmf_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_TABLE_LEN     = 24;
    localparam int ANG_W             = 28;  // Q.24 angle, sign and 3 integer bits
    localparam int VEC_W             = 42;  // vectoring datapath width
    localparam int ROT_W             = 28;  // rotation datapath width
    localparam int X_W               = 32;  // scaled slip B*s in Q.24
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic signed [ANG_W-1:0] Q24_PI      = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] Q24_TWO_PI  = 28'sd105414357;
    localparam logic signed [ANG_W-1:0] Q24_ONE     = 28'sd16777216;
    localparam logic signed [ANG_W-1:0] Q24_GAIN    = 28'sd10188014;

    localparam logic signed [17:0] FORCE_MAX = 18'sd131071;
    localparam logic signed [17:0] FORCE_MIN = -18'sd131072;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STIFFNESS_B   = 3'd0,
        REG_SHAPE_C       = 3'd1,
        REG_PEAK_D        = 3'd2,
        REG_CURVATURE_E   = 3'd3,
        REG_VERTICAL_LOAD = 3'd4
    } cfg_reg_t;

    function automatic logic signed [ANG_W-1:0] cordic_angle(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:  a = 28'sd13176795;
            1:  a = 28'sd7778716;
            2:  a = 28'sd4110060;
            3:  a = 28'sd2086331;
            4:  a = 28'sd1047214;
            5:  a = 28'sd524117;
            6:  a = 28'sd262123;
            7:  a = 28'sd131069;
            8:  a = 28'sd65536;
            9:  a = 28'sd32768;
            10: a = 28'sd16384;
            11: a = 28'sd8192;
            12: a = 28'sd4096;
            13: a = 28'sd2048;
            14: a = 28'sd1024;
            15: a = 28'sd512;
            16: a = 28'sd256;
            17: a = 28'sd128;
            18: a = 28'sd64;
            19: a = 28'sd32;
            20: a = 28'sd16;
            21: a = 28'sd8;
            22: a = 28'sd4;
            23: a = 28'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/tire_magic_formula_eval_core.sv
// ----------------------------------------------------------------------------
// tire_magic_formula_eval_core: magic formula tire force, one slip per cycle
// F = Fz*D*sin(C*atan(B*s - E*(B*s - atan(B*s)))), saturated to 18 bits.
// ----------------------------------------------------------------------------
// Three chained pipelined CORDIC units of N stages each (N = 16 by default,
// capped at 24) sit between the registered arithmetic stages below.
// Throughput: one transaction per cycle; a stalled output freezes the pipe.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults B=8.0, C=0.5, D=1.1, E=-4.5, Fz=0.
module tire_magic_formula_eval_core #(
    parameter int CORDIC_STAGES = tmf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [17:0] slip_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [17:0] tire_force
    output logic                           m_tuser,   // [0] saturated
    input  logic                           cfg_wr_en,
    input  logic [tmf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tmf_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    localparam int ANG_W = tmf_pkg::ANG_W;
    localparam int VEC_W = tmf_pkg::VEC_W;
    localparam int X_W   = tmf_pkg::X_W;
    localparam int ROT_W = tmf_pkg::ROT_W;

    logic               en;
    logic [15:0]        b_reg, c_reg, d_reg, fz_reg;
    logic signed [15:0] e_reg;
    logic [31:0]        load_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg  <= 16'd32768;
            c_reg  <= 16'd8192;
            d_reg  <= 16'd18022;
            e_reg  <= -16'sd9216;
            fz_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tmf_pkg::REG_STIFFNESS_B:   b_reg  <= cfg_wr_data;
                tmf_pkg::REG_SHAPE_C:       c_reg  <= cfg_wr_data;
                tmf_pkg::REG_PEAK_D:        d_reg  <= cfg_wr_data;
                tmf_pkg::REG_CURVATURE_E:   e_reg  <= $signed(cfg_wr_data);
                tmf_pkg::REG_VERTICAL_LOAD: fz_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // User keeps Fz*D changes to idle, unchecked; free-running reg suffices
    always_ff @(posedge aclk) begin
        load_reg <= fz_reg * d_reg;
    end

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    // stage: x = (s*B) >> 2
    logic signed [17:0]    slip;
    logic signed [34:0]    sb_prod;
    logic signed [X_W-1:0] x_reg;
    logic                  x_vld_reg;

    assign slip    = $signed(s_tdata[17:0]);
    assign sb_prod = slip * $signed({1'b0, b_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) x_vld_reg <= 1'b0;
        else if (en)  x_vld_reg <= s_tvalid;
        if (en)       x_reg     <= X_W'(sb_prod >>> 2);
    end

    // first arctangent, x carried alongside
    logic                  a1_vld;
    logic signed [ANG_W-1:0] a1;
    logic [X_W-1:0]        a1_x;

    tmf_cordic_vec #(.STAGES(CORDIC_STAGES), .W(VEC_W), .SW(X_W)) u_atan1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(x_vld_reg), .in_v(VEC_W'(x_reg)), .in_side(x_reg),
        .out_valid(a1_vld), .out_z(a1), .out_side(a1_x)
    );

    // stage: t = (E*(x - a1)) >> 11
    logic signed [32:0]    diff;
    logic signed [48:0]    e_prod;
    logic signed [37:0]    t_reg;
    logic signed [X_W-1:0] xt_reg;
    logic                  t_vld_reg;

    assign diff   = 33'($signed(a1_x)) - 33'(a1);
    assign e_prod = e_reg * diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) t_vld_reg <= 1'b0;
        else if (en)  t_vld_reg <= a1_vld;
        if (en) begin
            t_reg  <= 38'(e_prod >>> 11);
            xt_reg <= $signed(a1_x);
        end
    end

    // stage: u = x - t
    logic signed [38:0] u_reg;
    logic               u_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) u_vld_reg <= 1'b0;
        else if (en)  u_vld_reg <= t_vld_reg;
        if (en)       u_reg     <= 39'(xt_reg) - 39'(t_reg);
    end

    // second arctangent
    logic                    a2_vld;
    logic signed [ANG_W-1:0] a2;
    logic [0:0]              a2_side;

    tmf_cordic_vec #(.STAGES(CORDIC_STAGES), .W(VEC_W), .SW(1)) u_atan2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(u_vld_reg), .in_v(VEC_W'(u_reg)), .in_side(u_vld_reg),
        .out_valid(a2_vld), .out_z(a2), .out_side(a2_side)
    );

    // stage: th = (C*a2) >> 14
    logic signed [44:0]      c_prod;
    logic signed [ANG_W-1:0] th_reg;
    logic                    th_vld_reg;

    assign c_prod = $signed({1'b0, c_reg}) * a2;

    always_ff @(posedge aclk) begin
        if (!aresetn) th_vld_reg <= 1'b0;
        else if (en)  th_vld_reg <= a2_vld && a2_side[0];
        if (en)       th_reg     <= ANG_W'(c_prod >>> 14);
    end

    // stage: wrap to (-pi, pi], fold into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] wrap, fold;
    logic signed [ANG_W-1:0] fold_reg;
    logic                    fold_vld_reg;

    always_comb begin
        if (th_reg > tmf_pkg::Q24_PI)        wrap = th_reg - tmf_pkg::Q24_TWO_PI;
        else if (th_reg <= -tmf_pkg::Q24_PI) wrap = th_reg + tmf_pkg::Q24_TWO_PI;
        else                                 wrap = th_reg;
        if (wrap > tmf_pkg::Q24_HALF_PI)       fold = tmf_pkg::Q24_PI - wrap;
        else if (wrap < -tmf_pkg::Q24_HALF_PI) fold = -tmf_pkg::Q24_PI - wrap;
        else                                   fold = wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fold_vld_reg <= 1'b0;
        else if (en)  fold_vld_reg <= th_vld_reg;
        if (en)       fold_reg     <= fold;
    end

    // sine
    logic                    sn_vld;
    logic signed [ROT_W-1:0] sn;

    tmf_cordic_rot #(.STAGES(CORDIC_STAGES), .W(ROT_W)) u_sin (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(fold_vld_reg), .in_theta(fold_reg),
        .out_valid(sn_vld), .out_sin(sn)
    );

    // stage: Fz*D*sn
    logic signed [60:0] f_prod_reg;
    logic               f_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg  <= 1'b0;
        else if (en)  f_vld_reg  <= sn_vld;
        if (en)       f_prod_reg <= $signed({1'b0, load_reg}) * sn;
    end

    // stage: round half up, saturate, output register
    logic signed [61:0] f_rnd;
    logic signed [23:0] f_full;
    logic signed [17:0] force_next;
    logic               sat_next;
    logic signed [17:0] force_reg;
    logic               sat_reg;
    logic               out_vld_reg;

    always_comb begin
        f_rnd  = 62'(f_prod_reg) + (62'sd1 <<< 37);
        f_full = 24'(f_rnd >>> 38);
        if (f_full > 24'(tmf_pkg::FORCE_MAX)) begin
            force_next = tmf_pkg::FORCE_MAX;
            sat_next   = 1'b1;
        end else if (f_full < 24'(tmf_pkg::FORCE_MIN)) begin
            force_next = tmf_pkg::FORCE_MIN;
            sat_next   = 1'b1;
        end else begin
            force_next = f_full[17:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en)  out_vld_reg <= f_vld_reg;
        if (en) begin
            force_reg <= force_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, force_reg};
    assign m_tuser  = sat_reg;

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (force_reg == tmf_pkg::FORCE_MAX) || (force_reg == tmf_pkg::FORCE_MIN))
        else $error("saturation flag without clamped force");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready does not track output stage");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// File: rtl/tmf_cordic_vec.sv
// ----------------------------------------------------------------------------
// tmf_cordic_vec: pipelined CORDIC arctangent
// Rotates (1, v) onto the positive x axis, one iteration per register stage.
// ----------------------------------------------------------------------------
module tmf_cordic_vec #(
    parameter int STAGES = tmf_pkg::CORDIC_STAGES_DEF,
    parameter int W      = tmf_pkg::VEC_W,
    parameter int SW     = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [W-1:0]              in_v,
    input  logic [SW-1:0]                    in_side,
    output logic                             out_valid,
    output logic signed [tmf_pkg::ANG_W-1:0] out_z,
    output logic [SW-1:0]                    out_side
);
    localparam int NS = (STAGES > tmf_pkg::ANG_TABLE_LEN) ? tmf_pkg::ANG_TABLE_LEN : STAGES;

    logic signed [W-1:0]              x_reg [NS];
    logic signed [W-1:0]              y_reg [NS];
    logic signed [tmf_pkg::ANG_W-1:0] z_reg [NS];
    logic [SW-1:0]                    side_reg [NS];
    logic                             vld_reg [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic signed [W-1:0]              xi, yi, x_next, y_next;
            logic signed [tmf_pkg::ANG_W-1:0] zi, z_next;
            logic [SW-1:0]                    si;
            logic                             vi;

            if (k == 0) begin : g_first
                assign xi = W'(tmf_pkg::Q24_ONE);
                assign yi = in_v;
                assign zi = '0;
                assign si = in_side;
                assign vi = in_valid;
            end else begin : g_next
                assign xi = x_reg[k-1];
                assign yi = y_reg[k-1];
                assign zi = z_reg[k-1];
                assign si = side_reg[k-1];
                assign vi = vld_reg[k-1];
            end

            always_comb begin
                if (yi > 0) begin
                    x_next = xi + (yi >>> k);
                    y_next = yi - (xi >>> k);
                    z_next = zi + tmf_pkg::cordic_angle(k);
                end else begin
                    x_next = xi - (yi >>> k);
                    y_next = yi + (xi >>> k);
                    z_next = zi - tmf_pkg::cordic_angle(k);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vi;
                end
                if (en) begin
                    x_reg[k]    <= x_next;
                    y_reg[k]    <= y_next;
                    z_reg[k]    <= z_next;
                    side_reg[k] <= si;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_z     = z_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// File: rtl/tmf_cordic_rot.sv
// ----------------------------------------------------------------------------
// tmf_cordic_rot: pipelined CORDIC sine
// Rotates (K, 0) by an angle in [-pi/2, pi/2], one iteration per stage.
// ----------------------------------------------------------------------------
module tmf_cordic_rot #(
    parameter int STAGES = tmf_pkg::CORDIC_STAGES_DEF,
    parameter int W      = tmf_pkg::ROT_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [tmf_pkg::ANG_W-1:0] in_theta,
    output logic                             out_valid,
    output logic signed [W-1:0]              out_sin
);
    localparam int NS = (STAGES > tmf_pkg::ANG_TABLE_LEN) ? tmf_pkg::ANG_TABLE_LEN : STAGES;

    logic signed [W-1:0]              x_reg [NS];
    logic signed [W-1:0]              y_reg [NS];
    logic signed [tmf_pkg::ANG_W-1:0] z_reg [NS];
    logic                             vld_reg [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic signed [W-1:0]              xi, yi, x_next, y_next;
            logic signed [tmf_pkg::ANG_W-1:0] zi, z_next;
            logic                             vi;

            if (k == 0) begin : g_first
                assign xi = W'(tmf_pkg::Q24_GAIN);
                assign yi = '0;
                assign zi = in_theta;
                assign vi = in_valid;
            end else begin : g_next
                assign xi = x_reg[k-1];
                assign yi = y_reg[k-1];
                assign zi = z_reg[k-1];
                assign vi = vld_reg[k-1];
            end

            always_comb begin
                if (zi >= 0) begin
                    x_next = xi - (yi >>> k);
                    y_next = yi + (xi >>> k);
                    z_next = zi - tmf_pkg::cordic_angle(k);
                end else begin
                    x_next = xi + (yi >>> k);
                    y_next = yi - (xi >>> k);
                    z_next = zi + tmf_pkg::cordic_angle(k);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vi;
                end
                if (en) begin
                    x_reg[k] <= x_next;
                    y_reg[k] <= y_next;
                    z_reg[k] <= z_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_sin   = y_reg[NS-1];

endmodule
